// ===== rtl/dto_pkg.sv =====
package dto_pkg;

   // calendar and clock constants
   localparam int unsigned MinsPerHour = 60;
   localparam int unsigned HoursPerDay = 24;

   // divisibility by 25 through the multiplicative inverse modulo 2^16
   localparam logic [15:0] Inv25      = 16'd23593;
   localparam logic [15:0] Div25Limit = 16'd2621;

   // configuration register indexes
   localparam int unsigned CsrIndexWidth = 1;
   localparam int unsigned CsrDataWidth  = 6;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_OFFSET_HOURS   = 1'b0,
      CSR_OFFSET_MINUTES = 1'b1
   } csr_index_type;

   // input item
   typedef struct packed {
      logic        mode;
      logic [15:0] in_year;
      logic [3:0]  in_mon;
      logic [4:0]  in_day;
      logic [2:0]  in_weekday;
      logic [4:0]  in_hour;
      logic [5:0]  in_minute;
      logic [5:0]  in_second;
   } req_item_type;

   // result item
   typedef struct packed {
      logic [15:0] out_year;
      logic [3:0]  out_month;
      logic [4:0]  out_day;
      logic [2:0]  out_weekday;
      logic [4:0]  out_hour;
      logic [5:0]  out_minute;
      logic [5:0]  out_second;
   } rsp_item_type;

   // day step decided by the time of day arithmetic
   typedef struct packed {
      logic fwd;
      logic back;
   } day_step_type;

   // gregorian leap year: div by 4, and not by 100 unless by 400
   function automatic logic is_leap(input logic [15:0] year);
      logic [31:0] prod;
      logic        div4;
      logic        div16;
      logic        div25;
      prod  = 32'(year) * 32'(Inv25);
      div4  = (year[1:0] == 2'b00);
      div16 = (year[3:0] == 4'b0000);
      div25 = (prod[15:0] <= Div25Limit);
      return div4 && (!div25 || div16);
   endfunction

   // length of a month, month already in 1..12
   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// ===== rtl/dto_time.sv =====
module dto_time import dto_pkg::*; (
   input  req_item_type      item,
   input  logic signed [4:0] zone_hours,
   input  logic [5:0]        offset_minutes,
   output logic [4:0]        out_hour,
   output logic [5:0]        out_minute,
   output day_step_type      step
);

   logic [4:0]        hour_s;
   logic [5:0]        min_s;
   logic [5:0]        om_s;
   logic signed [4:0] oh_s;
   logic signed [5:0] oh_ext;
   logic signed [5:0] oh_eff;
   logic [5:0]        om_eff;
   logic [6:0]        m_sum;
   logic [6:0]        m_adj;
   logic              carry;
   logic signed [6:0] h_sum;
   logic signed [6:0] h_adj;

   // clamp inputs and offset into range
   always_comb begin
      hour_s = (item.in_hour > 5'd23) ? 5'd23 : item.in_hour;
      min_s  = (item.in_minute > 6'd59) ? 6'd59 : item.in_minute;
      om_s   = (offset_minutes > 6'd59) ? 6'd59 : offset_minutes;
      if (zone_hours < -5'sd12) begin
         oh_s = -5'sd12;
      end else if (zone_hours > 5'sd12) begin
         oh_s = 5'sd12;
      end else begin
         oh_s = zone_hours;
      end
   end

   // negate the offset for subtraction, borrowing an hour for the minutes
   always_comb begin
      oh_ext = {oh_s[4], oh_s};
      oh_eff = oh_ext;
      om_eff = om_s;
      if (item.mode) begin
         if (om_s != 6'd0) begin
            oh_eff = -oh_ext - 6'sd1;
            om_eff = 6'(MinsPerHour) - om_s;
         end else begin
            oh_eff = -oh_ext;
         end
      end
   end

   // minute add with carry, then hour add with day wrap
   always_comb begin
      m_sum = {1'b0, min_s} + {1'b0, om_eff};
      carry = (m_sum >= 7'(MinsPerHour));
      m_adj = carry ? (m_sum - 7'(MinsPerHour)) : m_sum;
      h_sum = $signed({2'b00, hour_s}) + $signed({6'b000000, carry})
            + $signed({oh_eff[5], oh_eff});
      step.fwd  = (h_sum >= $signed(7'(HoursPerDay)));
      step.back = h_sum[6];
      if (step.fwd) begin
         h_adj = h_sum - $signed(7'(HoursPerDay));
      end else if (step.back) begin
         h_adj = h_sum + $signed(7'(HoursPerDay));
      end else begin
         h_adj = h_sum;
      end
      out_hour   = h_adj[4:0];
      out_minute = m_adj[5:0];
   end

endmodule

// ===== rtl/dto_date.sv =====
module dto_date import dto_pkg::*; (
   input  req_item_type item,
   input  day_step_type step,
   output logic [15:0]  out_year,
   output logic [3:0]   out_month,
   output logic [4:0]   out_day,
   output logic [2:0]   out_weekday
);

   logic [3:0] month_s;
   logic [3:0] prev_month;
   logic       leap;
   logic [4:0] cur_len;

   // clamp month and look up lengths for this year
   always_comb begin
      if (item.in_mon == 4'd0) begin
         month_s = 4'd1;
      end else if (item.in_mon > 4'd12) begin
         month_s = 4'd12;
      end else begin
         month_s = item.in_mon;
      end
      prev_month = month_s - 4'd1;
      leap       = is_leap(item.in_year);
      cur_len    = month_len(month_s, leap);
   end

   // one day forward or back across month and year ends
   always_comb begin
      out_year    = item.in_year;
      out_month   = month_s;
      out_day     = item.in_day;
      out_weekday = item.in_weekday;
      if (step.fwd) begin
         out_weekday = (item.in_weekday >= 3'd7) ? 3'd1 : (item.in_weekday + 3'd1);
         if (item.in_day >= cur_len) begin
            out_day = 5'd1;
            if (month_s == 4'd12) begin
               out_month = 4'd1;
               out_year  = item.in_year + 16'd1;
            end else begin
               out_month = month_s + 4'd1;
            end
         end else begin
            out_day = item.in_day + 5'd1;
         end
      end else if (step.back) begin
         out_weekday = (item.in_weekday <= 3'd1) ? 3'd7 : (item.in_weekday - 3'd1);
         if (item.in_day <= 5'd1) begin
            if (month_s == 4'd1) begin
               out_month = 4'd12;
               out_year  = item.in_year - 16'd1;
               out_day   = 5'd31;
            end else begin
               out_month = prev_month;
               out_day   = month_len(prev_month, leap);
            end
         end else begin
            out_day = item.in_day - 5'd1;
         end
      end
   end

endmodule

// ===== rtl/datetime_offset_adjust.sv =====
// Adds or subtracts a programmed time zone offset (signed hours plus a minute
// part) to a civil date and time, rolling days over months and years with
// Gregorian leap years and stepping the weekday along. One item is accepted
// every cycle while the result side does not stall; an accepted item goes
// through the input register and the calendar logic into the result register.
// Stall on the result side holds the result register and then the input
// register. Program the offset through the csr port only while no item is in
// flight; csr writes are always taken.
module datetime_offset_adjust import dto_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_item_type             req_item,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_item_type             rsp_item,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  csr_index_type            csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   logic signed [4:0] zone_hours_ff;
   logic [5:0]        offset_minutes_ff;
   logic              s1_valid_ff;
   logic              s1_valid_in;
   req_item_type      s1_item_ff;
   req_item_type      s1_item_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   rsp_item_type      out_item_ff;
   rsp_item_type      out_item_in;
   logic              out_free;
   logic              s1_free;
   rsp_item_type      calc_item;
   day_step_type      step;
   logic [4:0]        calc_hour;
   logic [5:0]        calc_minute;
   logic [15:0]       calc_year;
   logic [3:0]        calc_month;
   logic [4:0]        calc_day;
   logic [2:0]        calc_weekday;

   // offset registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_hours_ff     <= 5'sd0;
         offset_minutes_ff <= 6'd0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_OFFSET_HOURS:   zone_hours_ff     <= $signed(csr_data[4:0]);
            CSR_OFFSET_MINUTES: offset_minutes_ff <= csr_data[5:0];
            default:            ;
         endcase
      end
   end

   // time of day arithmetic
   dto_time u_time (
      .item           (s1_item_ff),
      .zone_hours     (zone_hours_ff),
      .offset_minutes (offset_minutes_ff),
      .out_hour       (calc_hour),
      .out_minute     (calc_minute),
      .step           (step)
   );

   // calendar day step
   dto_date u_date (
      .item        (s1_item_ff),
      .step        (step),
      .out_year    (calc_year),
      .out_month   (calc_month),
      .out_day     (calc_day),
      .out_weekday (calc_weekday)
   );

   // gather the result item
   always_comb begin
      calc_item.out_year    = calc_year;
      calc_item.out_month   = calc_month;
      calc_item.out_day     = calc_day;
      calc_item.out_weekday = calc_weekday;
      calc_item.out_hour    = calc_hour;
      calc_item.out_minute  = calc_minute;
      calc_item.out_second  = s1_item_ff.in_second;
   end

   // pipeline flow control
   always_comb begin
      out_free     = !out_valid_ff || !rsp_stall;
      s1_free      = !s1_valid_ff || out_free;
      req_stall    = !s1_free;
      s1_valid_in  = s1_free ? req_valid : s1_valid_ff;
      s1_item_in   = (s1_free && req_valid) ? req_item : s1_item_ff;
      out_valid_in = out_free ? s1_valid_ff : out_valid_ff;
      out_item_in  = (out_free && s1_valid_ff) ? calc_item : out_item_ff;
   end

   // stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   // an empty input stage never stalls the requester
   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !req_stall)
      else $error("input stage empty but stalling");

   // a held item moves on whenever the result register frees up
   a_item_advances: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_free) |=> out_valid_ff)
      else $error("item lost between stages");

   // results stay within the clock ranges
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.out_hour <= 5'd23 && rsp_item.out_minute <= 6'd59))
      else $error("result time out of range");

   // result month is always a real month
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.out_month >= 4'd1 && rsp_item.out_month <= 4'd12))
      else $error("result month out of range");

endmodule

// ===== bench/datetime_offset_adjust_tb.sv =====
`timescale 1ns / 1ps

module datetime_offset_adjust_tb;
   import dto_pkg::*;

   // item mode codes
   localparam logic MODE_ADD = 1'b0;
   localparam logic MODE_SUB = 1'b1;

   localparam int unsigned IdleLimit   = 4000;
   localparam int unsigned SegmentLen  = 205;
   localparam int unsigned PrintLimit  = 40;

   // one directed row: zone setting, item, and a hand-written result where obvious
   typedef struct packed {
      logic [4:0]   zone_hours;
      logic [5:0]   zone_minutes;
      req_item_type item;
      logic         typed;
      rsp_item_type want;
   } zone_case_type;

   // negative zone hours are 5-bit two's complement: 5'h14 = -12, 5'h10 = -16, 5'h1F = -1
   localparam zone_case_type ZONE_CASES [17] = '{
      // reset zone, add and subtract leave the item as it is
      '{5'd0, 6'd0, '{MODE_ADD, 16'd2024, 4'd2, 5'd29, 3'd4, 5'd12, 6'd30, 6'd45}, 1'b1,
        '{16'd2024, 4'd2, 5'd29, 3'd4, 5'd12, 6'd30, 6'd45}},
      '{5'd0, 6'd0, '{MODE_SUB, 16'd2024, 4'd2, 5'd29, 3'd4, 5'd12, 6'd30, 6'd45}, 1'b1,
        '{16'd2024, 4'd2, 5'd29, 3'd4, 5'd12, 6'd30, 6'd45}},
      // largest forward step wraps the year to 0
      '{5'd12, 6'd59, '{MODE_ADD, 16'd65535, 4'd12, 5'd31, 3'd7, 5'd23, 6'd59, 6'd59}, 1'b1,
        '{16'd0, 4'd1, 5'd1, 3'd1, 5'd12, 6'd58, 6'd59}},
      // largest backward step wraps year 0 to 65535
      '{5'h14, 6'd0, '{MODE_ADD, 16'd0, 4'd1, 5'd1, 3'd1, 5'd0, 6'd0, 6'd0}, 1'b1,
        '{16'd65535, 4'd12, 5'd31, 3'd7, 5'd12, 6'd0, 6'd0}},
      // leap year rules on backward and forward steps
      '{5'd12, 6'd0, '{MODE_SUB, 16'd2000, 4'd3, 5'd1, 3'd3, 5'd5, 6'd0, 6'd0}, 1'b0, '0},
      '{5'd12, 6'd0, '{MODE_SUB, 16'd1900, 4'd3, 5'd1, 3'd4, 5'd5, 6'd0, 6'd0}, 1'b0, '0},
      '{5'd12, 6'd0, '{MODE_ADD, 16'd2024, 4'd2, 5'd28, 3'd3, 5'd20, 6'd0, 6'd0}, 1'b0, '0},
      '{5'd12, 6'd0, '{MODE_ADD, 16'd2023, 4'd2, 5'd28, 3'd2, 5'd20, 6'd0, 6'd0}, 1'b0, '0},
      '{5'd12, 6'd0, '{MODE_ADD, 16'd2100, 4'd2, 5'd28, 3'd7, 5'd20, 6'd0, 6'd0}, 1'b0, '0},
      '{5'd12, 6'd0, '{MODE_SUB, 16'd0, 4'd3, 5'd1, 3'd1, 5'd3, 6'd0, 6'd0}, 1'b0, '0},
      // zone and item fields beyond range get saturated
      '{5'h0F, 6'd63, '{MODE_ADD, 16'd2024, 4'd0, 5'd0, 3'd0, 5'd31, 6'd63, 6'd63}, 1'b0, '0},
      '{5'h10, 6'd63, '{MODE_SUB, 16'd2024, 4'd15, 5'd31, 3'd7, 5'd31, 6'd0, 6'd60}, 1'b0, '0},
      // day past month end is copied when there is no step
      '{5'd0, 6'd0, '{MODE_ADD, 16'd2023, 4'd4, 5'd31, 3'd5, 5'd10, 6'd20, 6'd30}, 1'b1,
        '{16'd2023, 4'd4, 5'd31, 3'd5, 5'd10, 6'd20, 6'd30}},
      // backward step from day 0 and weekday 0
      '{5'h1F, 6'd0, '{MODE_ADD, 16'd2023, 4'd3, 5'd0, 3'd0, 5'd0, 6'd15, 6'd5}, 1'b0, '0},
      // forward step from a day past month end
      '{5'd1, 6'd0, '{MODE_ADD, 16'd2023, 4'd6, 5'd31, 3'd7, 5'd23, 6'd0, 6'd0}, 1'b0, '0},
      // subtract with a minute part
      '{5'd3, 6'd30, '{MODE_SUB, 16'd2023, 4'd1, 5'd1, 3'd1, 5'd2, 6'd15, 6'd0}, 1'b0, '0},
      // minute carry alone pushes into the next day
      '{5'd0, 6'd45, '{MODE_ADD, 16'd2023, 4'd5, 5'd15, 3'd6, 5'd23, 6'd59, 6'd0}, 1'b0, '0}
   };

   logic          clock;
   logic          reset        = 1'b1;
   logic          req_valid    = 1'b0;
   logic          req_stall;
   req_item_type  req_item     = '0;
   logic          rsp_valid;
   logic          rsp_stall    = 1'b0;
   rsp_item_type  rsp_item;
   logic          csr_valid    = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index    = CSR_OFFSET_HOURS;
   logic [CsrDataWidth-1:0] csr_data = '0;

   // zone registers as the block should hold them
   logic [4:0]    zone_hours_q   = '0;
   logic [5:0]    zone_minutes_q = '0;

   rsp_item_type  pending_local_q [$];
   int unsigned   err_count  = 0;
   int unsigned   idle_pct   = 0;
   int unsigned   stall_pct  = 0;
   int unsigned   idle_cycles = 0;

   datetime_offset_adjust u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // month length with gregorian leap years, month already in 1..12
   function automatic int unsigned month_length(int unsigned yr, int unsigned mo);
      int unsigned len;
      case (mo)
         2:       len = 28;
         4, 6, 9, 11: len = 30;
         default: len = 31;
      endcase
      if (mo == 2 && (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0)))
         len = 29;
      return len;
   endfunction

   // local time after applying the current zone offset
   function automatic rsp_item_type shift_local_time(req_item_type it);
      int          zh;
      int          zm;
      int          h;
      int          m;
      int unsigned yr;
      int unsigned mo;
      int unsigned dy;
      int unsigned wd;
      rsp_item_type r;
      yr = it.in_year;
      mo = (it.in_mon == 0) ? 1 : (it.in_mon > 12) ? 12 : it.in_mon;
      dy = it.in_day;
      wd = it.in_weekday;
      h  = (it.in_hour > 23) ? 23 : it.in_hour;
      m  = (it.in_minute > 59) ? 59 : it.in_minute;
      zh = $signed(zone_hours_q);
      if (zh < -12) zh = -12;
      if (zh > 12) zh = 12;
      zm = (zone_minutes_q > 59) ? 59 : zone_minutes_q;

      // subtract negates the offset, borrowing an hour for the minute part
      if (it.mode == MODE_SUB) begin
         zh = -zh;
         if (zm != 0) begin
            zm = int'(MinsPerHour) - zm;
            zh = zh - 1;
         end
      end

      m = m + zm;
      if (m >= int'(MinsPerHour)) begin
         m = m - int'(MinsPerHour);
         h = h + 1;
      end
      h = h + zh;

      // one day forward or back
      if (h >= int'(HoursPerDay)) begin
         h  = h - int'(HoursPerDay);
         wd = (wd >= 7) ? 1 : wd + 1;
         if (dy >= month_length(yr, mo)) begin
            dy = 1;
            if (mo == 12) begin
               mo = 1;
               yr = (yr + 1) % 65536;
            end else begin
               mo = mo + 1;
            end
         end else begin
            dy = dy + 1;
         end
      end else if (h < 0) begin
         h  = h + int'(HoursPerDay);
         wd = (wd <= 1) ? 7 : wd - 1;
         if (dy <= 1) begin
            if (mo == 1) begin
               mo = 12;
               yr = (yr + 65535) % 65536;
               dy = 31;
            end else begin
               mo = mo - 1;
               dy = month_length(yr, mo);
            end
         end else begin
            dy = dy - 1;
         end
      end

      r.out_year    = yr[15:0];
      r.out_month   = mo[3:0];
      r.out_day     = dy[4:0];
      r.out_weekday = wd[2:0];
      r.out_hour    = h[4:0];
      r.out_minute  = m[5:0];
      r.out_second  = it.in_second;
      return r;
   endfunction

   // mostly well-formed dates leaning on month and day edges, some raw noise
   function automatic req_item_type random_datetime();
      logic [63:0]  noise;
      req_item_type it;
      int unsigned  len;
      noise = {$urandom(), $urandom()};
      if ($urandom_range(99) < 15)
         return noise[$bits(req_item_type)-1:0];
      it.mode = 1'($urandom_range(1));
      case ($urandom_range(7))
         0:       it.in_year = 16'd0;
         1:       it.in_year = 16'd1900;
         2:       it.in_year = 16'd2000;
         3:       it.in_year = 16'd2100;
         4:       it.in_year = 16'd65535;
         default: it.in_year = noise[63:48];
      endcase
      it.in_mon = 4'($urandom_range(12, 1));
      len = month_length(it.in_year, it.in_mon);
      case ($urandom_range(3))
         0:       it.in_day = 5'd1;
         1:       it.in_day = len[4:0];
         default: it.in_day = 5'($urandom_range(len, 1));
      endcase
      it.in_weekday = 3'($urandom_range(7, 1));
      if ($urandom_range(1))
         it.in_hour = 5'($urandom_range(23));
      else if ($urandom_range(1))
         it.in_hour = 5'(23 - $urandom_range(1));
      else
         it.in_hour = 5'($urandom_range(1));
      it.in_minute = 6'($urandom_range(59));
      it.in_second = 6'($urandom_range(59));
      return it;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      err_count++;
      if (err_count <= PrintLimit)
         $display("mismatch %s: got %0d expected %0d", what, got, want);
   endtask

   // send one item after a random gap, record its expected result on acceptance
   task automatic send_datetime(input req_item_type item, input logic typed,
                                input rsp_item_type want);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      do @(posedge clock); while (req_stall);
      pending_local_q.push_back(typed ? want : shift_local_time(item));
   endtask

   // program both zone registers once the pipeline is empty
   task automatic set_zone(input logic [4:0] hours, input logic [5:0] minutes);
      req_valid <= 1'b0;
      while (pending_local_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_OFFSET_HOURS;
      csr_data  <= {1'($urandom_range(1)), hours};
      do @(posedge clock); while (!csr_ready);
      zone_hours_q = hours;
      csr_index <= CSR_OFFSET_MINUTES;
      csr_data  <= minutes;
      do @(posedge clock); while (!csr_ready);
      zone_minutes_q = minutes;
      csr_valid <= 1'b0;
   endtask

   // receiver stall
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_local_q.size() == 0) begin
            report_mismatch("result with no item pending", rsp_item.out_year, 0);
         end else begin
            want = pending_local_q.pop_front();
            if (rsp_item.out_year !== want.out_year)
               report_mismatch("out_year", rsp_item.out_year, want.out_year);
            if (rsp_item.out_month !== want.out_month)
               report_mismatch("out_month", rsp_item.out_month, want.out_month);
            if (rsp_item.out_day !== want.out_day)
               report_mismatch("out_day", rsp_item.out_day, want.out_day);
            if (rsp_item.out_weekday !== want.out_weekday)
               report_mismatch("out_weekday", rsp_item.out_weekday, want.out_weekday);
            if (rsp_item.out_hour !== want.out_hour)
               report_mismatch("out_hour", rsp_item.out_hour, want.out_hour);
            if (rsp_item.out_minute !== want.out_minute)
               report_mismatch("out_minute", rsp_item.out_minute, want.out_minute);
            if (rsp_item.out_second !== want.out_second)
               report_mismatch("out_second", rsp_item.out_second, want.out_second);
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus
   initial begin
      zone_case_type row;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed rows, zone rewritten only where the row asks for a new one
      foreach (ZONE_CASES[i]) begin
         row = ZONE_CASES[i];
         if (row.zone_hours != zone_hours_q || row.zone_minutes != zone_minutes_q)
            set_zone(row.zone_hours, row.zone_minutes);
         send_datetime(row.item, row.typed, row.want);
      end

      // random segments, each with its own zone and idling pattern
      for (int seg = 0; seg < 8; seg++) begin
         case (seg)
            0:       set_zone(5'd12, 6'd59);
            1:       set_zone(5'h14, 6'd59);
            2:       set_zone(5'h10, 6'd0);
            3:       set_zone(5'h0F, 6'd63);
            4:       set_zone(5'd0, 6'd1);
            default: set_zone(5'($urandom()), 6'($urandom()));
         endcase
         case (seg % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 73; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 73; end
            default: begin idle_pct = 21; stall_pct = 21; end
         endcase
         repeat (SegmentLen) send_datetime(random_datetime(), 1'b0, '0);
      end

      // drain and settle
      req_valid <= 1'b0;
      while (pending_local_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (err_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
